FILE: src/gds_pkg.sv
// Package for the Gregorian date step unit: codes, year limits and calendar tables.
// No dependencies.
package gds_pkg;

  localparam int YearBits = 16;
  localparam int YearW    = 16;
  localparam int DayW     = 5;
  localparam int MonthW   = 4;
  localparam int YdayW    = 9;
  localparam int CmpW     = 33;

  localparam logic [CmpW-1:0] YearMax = (CmpW'(1) << YearBits) - CmpW'(1);

  // y is a multiple of 25 iff y * inv(25) mod 2^16 <= (2^16 - 1) / 25
  localparam logic [YearW-1:0] InvTwentyFive = 16'h5C29;
  localparam logic [YearW-1:0] DivTwentyFiveMax = YearW'(65535 / 25);

  typedef enum logic [1:0] {
    FuncNext     = 2'd0,
    FuncPrev     = 2'd1,
    FuncYearDay  = 2'd2,
    FuncValidate = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadDate = 2'd1,
    StRange   = 2'd2,
    StUnused  = 2'd3
  } status_e;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      default:                                    len = leap ? 5'd29 : 5'd28;
    endcase
    return len;
  endfunction

  function automatic logic [YdayW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [YdayW-1:0] db;
    case (m)
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage

FILE: src/gregorian_date_step_unit.sv
// Gregorian date step unit: next day, previous day, day of year and date check.
// Depends on gds_pkg for codes, year limits and calendar tables.
//
// Usage: a request (func, day, month, year) enters on in_valid_i when in_stall_o
// is low. Each request gives one result (date, day of year, leap flag, status)
// on out_valid_o, taken when out_stall_i is low. Results keep request order.
// Each request passes in order through the three register stages (leap test
// product, month tables and checks, date update), and out_valid_o rises once
// the result is held in the third. Throughput, set by these stages, is one
// request per cycle while the receiver does not stall. Each stage holds its
// data while the stage after it is full and stalled, so a stalled receiver
// fills the pipe and then raises in_stall_o; bubbles are squeezed out
// meanwhile. A stalled result holds steady. Reset clears the stage valid bits
// only; no request is pending after reset and the unit keeps no state between requests.
//
module gregorian_date_step_unit
  import gds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [DayW-1:0]   day_in_i,
  input  logic [MonthW-1:0] month_in_i,
  input  logic [YearW-1:0]  year_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DayW-1:0]   day_out_o,
  output logic [MonthW-1:0] month_out_o,
  output logic [YearW-1:0]  year_out_o,
  output logic [YdayW-1:0]  year_day_o,
  output logic              is_leap_o,
  output logic [1:0]        status_o
);

  typedef struct packed {
    func_e             func;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } req_t;

  typedef struct packed {
    req_t             req;
    logic [YearW-1:0] prod;
    logic             yr_hi;
    logic             yr_max;
  } s1_t;

  typedef struct packed {
    req_t             req;
    logic             leap;
    logic             date_ok;
    logic             yr_hi;
    logic             yr_max;
    logic [DayW-1:0]  mlen;
    logic [DayW-1:0]  prev_len;
    logic [YdayW-1:0] yday_base;
  } s2_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [YdayW-1:0]  yday;
    logic              leap;
    status_e           status;
  } s3_t;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // stage 1: reciprocal product for the divide-by-25 test, year limit compares
  always_comb begin
    logic [CmpW-1:0] yw;
    yw = CmpW'(year_in_i);
    s1_d.req.func  = func_e'(func_i);
    s1_d.req.day   = day_in_i;
    s1_d.req.month = month_in_i;
    s1_d.req.year  = year_in_i;
    s1_d.prod      = YearW'(year_in_i * InvTwentyFive);
    s1_d.yr_hi     = yw > YearMax;
    s1_d.yr_max    = yw >= YearMax;
  end

  // stage 2: leap rule, month lengths, date check
  always_comb begin
    logic div25;
    logic leap;
    logic [DayW-1:0] mlen;
    div25 = s1_q.prod <= DivTwentyFiveMax;
    leap  = (s1_q.req.year[1:0] == 2'd0) && (!div25 || s1_q.req.year[3:0] == 4'd0);
    mlen  = month_len(s1_q.req.month, leap);
    s2_d.req       = s1_q.req;
    s2_d.leap      = leap;
    s2_d.yr_hi     = s1_q.yr_hi;
    s2_d.yr_max    = s1_q.yr_max;
    s2_d.mlen      = mlen;
    s2_d.prev_len  = month_len(s1_q.req.month - 4'd1, leap);
    s2_d.date_ok   = (s1_q.req.month >= 4'd1) && (s1_q.req.month <= 4'd12) &&
                     (s1_q.req.day != 5'd0) && (s1_q.req.day <= mlen);
    s2_d.yday_base = days_before(s1_q.req.month) +
                     YdayW'((s1_q.req.month > 4'd2) && leap);
  end

  // stage 3: date update and status
  always_comb begin
    s3_d.day    = s2_q.req.day;
    s3_d.month  = s2_q.req.month;
    s3_d.year   = s2_q.req.year;
    s3_d.yday   = '0;
    s3_d.leap   = s2_q.leap;
    s3_d.status = StOk;
    if (!s2_q.date_ok) begin
      s3_d.status = StBadDate;
    end else if (s2_q.yr_hi) begin
      s3_d.status = StRange;
    end else begin
      case (s2_q.req.func)
        FuncNext: begin
          if (s2_q.req.day < s2_q.mlen) begin
            s3_d.day = s2_q.req.day + 5'd1;
          end else if (s2_q.req.month < 4'd12) begin
            s3_d.day   = 5'd1;
            s3_d.month = s2_q.req.month + 4'd1;
          end else if (!s2_q.yr_max) begin
            s3_d.day   = 5'd1;
            s3_d.month = 4'd1;
            s3_d.year  = s2_q.req.year + YearW'(1);
          end else begin
            s3_d.status = StRange;
          end
        end
        FuncPrev: begin
          if (s2_q.req.day > 5'd1) begin
            s3_d.day = s2_q.req.day - 5'd1;
          end else if (s2_q.req.month > 4'd1) begin
            s3_d.month = s2_q.req.month - 4'd1;
            s3_d.day   = s2_q.prev_len;
          end else if (s2_q.req.year != '0) begin
            s3_d.day   = 5'd31;
            s3_d.month = 4'd12;
            s3_d.year  = s2_q.req.year - YearW'(1);
          end else begin
            s3_d.status = StRange;
          end
        end
        FuncYearDay: begin
          s3_d.yday = s2_q.yday_base + YdayW'(s2_q.req.day);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= s1_d;
    if (adv2 && v1_q) s2_q <= s2_d;
    if (adv3 && v2_q) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign day_out_o   = s3_q.day;
  assign month_out_o = s3_q.month;
  assign year_out_o  = s3_q.year;
  assign year_day_o  = s3_q.yday;
  assign is_leap_o   = s3_q.leap;
  assign status_o    = s3_q.status;

endmodule
